// ===== hw/rtl/shelf_atlas_packer_unit_assert.svh =====
// assertion macros for the shelf atlas packer
// expects i_clk and i_rst_n in the scope of use
`ifndef SHELF_ATLAS_PACKER_UNIT_ASSERT_SVH
`define SHELF_ATLAS_PACKER_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SAP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("shelf atlas packer check failed");

// next-cycle implication, checked out of reset
`define SAP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("shelf atlas packer check failed");

`endif

// ===== hw/rtl/sap_pkg.sv =====
// shared types and constants of the shelf atlas packer
// no dependencies
package sap_pkg;

    localparam int ATLAS_SIZE_DEF    = 1024;
    localparam int MAX_SHELVES_DEF   = 64;
    localparam int MAX_PER_SHELF_DEF = 256;

    // fixed field widths
    localparam int DIM_W    = 12;
    localparam int COORD_W  = 10;
    localparam int SHELF_W  = 6;
    localparam int STATUS_W = 2;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 32;

    typedef enum logic [STATUS_W-1:0] {
        STAT_PLACED   = 2'd0,
        STAT_TOO_WIDE = 2'd1,
        STAT_NO_ROOM  = 2'd2,
        STAT_CLEARED  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_OPEN,
        ST_EMIT
    } t_state;

endpackage

// ===== hw/rtl/shelf_atlas_packer_unit.sv =====
// shelf atlas packer top level: first-fit shelf placement over a shelf memory
// depends on sap_pkg and shelf_atlas_packer_unit_assert.svh
// sequence: a clear goes through ST_EMIT to the output register; a placement reads the open
// shelves in order in ST_SCAN, goes through ST_OPEN when none fits, then hands off in ST_EMIT
// throughput: one item at a time, a new one taken only in ST_IDLE; output stalls hold ST_EMIT
// reset: shelf count, atlas top and output valid clear; shelf memory is not cleared
`include "shelf_atlas_packer_unit_assert.svh"

module shelf_atlas_packer_unit #(
    parameter int ATLAS_SIZE    = sap_pkg::ATLAS_SIZE_DEF,
    parameter int MAX_SHELVES   = sap_pkg::MAX_SHELVES_DEF,
    parameter int MAX_PER_SHELF = sap_pkg::MAX_PER_SHELF_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // glyph_width [11:0], glyph_height [23:12]
    input  logic [sap_pkg::S_DATA_W-1:0]  s_axis_tdata,
    // kind [0]
    input  logic [0:0]                    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // origin_x [9:0], origin_y [19:10], shelf_index [25:20], zero [31:26]
    output logic [sap_pkg::M_DATA_W-1:0]  m_axis_tdata,
    // status [1:0]
    output logic [sap_pkg::STATUS_W-1:0]  m_axis_tuser
);
    import sap_pkg::*;

    // coordinate width holds 0..ATLAS_SIZE
    localparam int CW   = $clog2(ATLAS_SIZE + 1);
    // compare width for sums of coordinates and input dimensions
    localparam int SUMW = ((CW > DIM_W) ? CW : DIM_W) + 1;
    localparam int EW   = $clog2(MAX_PER_SHELF + 1);
    localparam int SW   = (MAX_SHELVES > 1) ? $clog2(MAX_SHELVES) : 1;
    localparam int NW   = $clog2(MAX_SHELVES + 1);

    typedef struct packed {
        logic [CW-1:0] baseline;
        logic [CW-1:0] height;
        logic [CW-1:0] next_x;
        logic [EW-1:0] entries;
    } t_shelf;

    // shelf memory: one write and one registered read per cycle
    t_shelf mem_shelf [MAX_SHELVES];
    t_shelf r_rd_data;
    logic            rd_en;
    logic [SW-1:0]   rd_addr;
    logic            wr_en;
    logic [SW-1:0]   wr_addr;
    t_shelf          wr_data;

    t_state          r_state, n_state;
    logic [NW-1:0]   r_open,  n_open;   // open shelf count
    logic [CW-1:0]   r_top,   n_top;    // top edge of the last shelf
    logic [SW-1:0]   r_idx,   n_idx;    // shelf whose data sits in r_rd_data

    // item under work
    logic [DIM_W-1:0] r_w, r_h;

    // pending result
    logic             load_pend;
    t_status          r_p_status, n_p_status;
    logic [COORD_W-1:0] r_p_x, n_p_x, r_p_y, n_p_y;
    logic [SHELF_W-1:0] r_p_s, n_p_s;

    // output register
    logic                 r_m_valid;
    logic [M_DATA_W-1:0]  r_m_data;
    t_status              r_m_status;

    logic s_xfer, out_free, emit;
    logic hit, more;
    logic [SUMW-1:0] new_top;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign s_xfer        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_m_valid || m_axis_tready;
    assign emit          = (r_state == ST_EMIT) && out_free;

    // fit test on the shelf read in the previous cycle
    assign hit = (SUMW'(r_h) <= SUMW'(r_rd_data.height))
              && (r_rd_data.entries < EW'(MAX_PER_SHELF))
              && (SUMW'(r_rd_data.next_x) + SUMW'(r_w) <= SUMW'(ATLAS_SIZE));
    // another open shelf left after this one
    assign more    = ((NW+1)'(r_idx) + 1'b1) < (NW+1)'(r_open);
    assign new_top = SUMW'(r_top) + SUMW'(r_h);

    always_comb begin
        n_state    = r_state;
        n_open     = r_open;
        n_top      = r_top;
        n_idx      = r_idx;
        rd_en      = 1'b0;
        rd_addr    = '0;
        wr_en      = 1'b0;
        wr_addr    = r_idx;
        wr_data    = r_rd_data;
        load_pend  = 1'b0;
        n_p_status = STAT_PLACED;
        n_p_x      = '0;
        n_p_y      = '0;
        n_p_s      = '0;
        case (r_state)
            ST_IDLE: begin
                if (s_xfer) begin
                    if (s_axis_tuser[0]) begin
                        // clear empties the atlas at once
                        n_open     = '0;
                        n_top      = '0;
                        load_pend  = 1'b1;
                        n_p_status = STAT_CLEARED;
                        n_state    = ST_EMIT;
                    end else if (r_open == '0) begin
                        n_state = ST_OPEN;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = '0;
                        n_idx   = '0;
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (hit) begin
                    // put the rectangle at the shelf's next free column
                    wr_en          = 1'b1;
                    wr_addr        = r_idx;
                    wr_data        = r_rd_data;
                    wr_data.next_x = CW'(SUMW'(r_rd_data.next_x) + SUMW'(r_w));
                    wr_data.entries = r_rd_data.entries + 1'b1;
                    load_pend      = 1'b1;
                    n_p_status     = STAT_PLACED;
                    n_p_x          = COORD_W'(r_rd_data.next_x);
                    n_p_y          = COORD_W'(r_rd_data.baseline);
                    n_p_s          = SHELF_W'(r_idx);
                    n_state        = ST_EMIT;
                end else if (more) begin
                    rd_en   = 1'b1;
                    rd_addr = SW'(r_idx + 1'b1);
                    n_idx   = SW'(r_idx + 1'b1);
                end else begin
                    n_state = ST_OPEN;
                end
            end
            ST_OPEN: begin
                load_pend = 1'b1;
                n_state   = ST_EMIT;
                if (SUMW'(r_w) > SUMW'(ATLAS_SIZE)) begin
                    n_p_status = STAT_TOO_WIDE;
                end else if (r_open >= NW'(MAX_SHELVES)
                             || new_top > SUMW'(ATLAS_SIZE)) begin
                    n_p_status = STAT_NO_ROOM;
                end else begin
                    // new shelf above the last one, holding this rectangle
                    wr_en            = 1'b1;
                    wr_addr          = SW'(r_open);
                    wr_data.baseline = r_top;
                    wr_data.height   = CW'(r_h);
                    wr_data.next_x   = CW'(r_w);
                    wr_data.entries  = EW'(1);
                    n_open           = r_open + 1'b1;
                    n_top            = CW'(new_top);
                    n_p_status       = STAT_PLACED;
                    n_p_x            = '0;
                    n_p_y            = COORD_W'(r_top);
                    n_p_s            = SHELF_W'(r_open);
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= mem_shelf[rd_addr];
        end
        if (wr_en) begin
            mem_shelf[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_open    <= '0;
            r_top     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_open  <= n_open;
            r_top   <= n_top;
            if (emit) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (s_xfer) begin
            r_w <= s_axis_tdata[DIM_W-1:0];
            r_h <= s_axis_tdata[2*DIM_W-1:DIM_W];
        end
        if (load_pend) begin
            r_p_status <= n_p_status;
            r_p_x      <= n_p_x;
            r_p_y      <= n_p_y;
            r_p_s      <= n_p_s;
        end
        if (emit) begin
            r_m_status <= r_p_status;
            r_m_data   <= {(M_DATA_W - 2*COORD_W - SHELF_W)'(0), r_p_s, r_p_y, r_p_x};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_status;

    `SAP_ASSERT_IMP(a_open_bound, 1'b1, r_open <= NW'(MAX_SHELVES))
    `SAP_ASSERT_IMP(a_top_bound, 1'b1, SUMW'(r_top) <= SUMW'(ATLAS_SIZE))
    `SAP_ASSERT_IMP(a_scan_in_range, r_state == ST_SCAN, (NW+1)'(r_idx) < (NW+1)'(r_open))
    `SAP_ASSERT_IMP(a_unplaced_zero, m_axis_tvalid && m_axis_tuser != STAT_PLACED,
                    m_axis_tdata == '0)
    `SAP_ASSERT_NEXT(a_clear_empties, s_xfer && s_axis_tuser[0], r_open == '0 && r_top == '0)

endmodule

// ===== tb/shelf_atlas_packer_unit_tb.sv =====
// self-checking bench for shelf_atlas_packer_unit: directed corner cases, then random
// episodes of placements under phases of source idling and sink stalls
// depends on sap_pkg and the rtl of shelf_atlas_packer_unit
module shelf_atlas_packer_unit_tb;
    import sap_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 7;
    // far beyond the slowest correct run, even with every scan at full depth
    localparam int LIMIT_CYCLES = 1_000_000;
    // room for a placement that scans every open shelf
    localparam int DRAIN_CYCLES = MAX_SHELVES_DEF + 40;
    localparam int PHASE_ITEMS  = 320;
    localparam int HOLD_CYCLES  = 600;

    // one request as the source sends it
    typedef struct {
        logic             kind;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } t_glyph_req;

    // one answer as the sink sees it
    typedef struct {
        t_status            status;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [SHELF_W-1:0] shelf;
    } t_placement;

    // flavors of random episodes, each aimed at one corner of the packer
    typedef enum {
        MIX_GLYPHS,
        MIX_SLIVERS,
        MIX_STRIPS,
        MIX_TALL,
        MIX_WILD
    } t_mix;

    localparam logic KIND_PLACE = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    // glyph_width [11:0], glyph_height [23:12]
    logic [S_DATA_W-1:0] s_axis_tdata  = '0;
    // kind [0]
    logic [0:0]          s_axis_tuser  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // origin_x [9:0], origin_y [19:10], shelf_index [25:20], zero [31:26]
    logic [M_DATA_W-1:0] m_axis_tdata;
    // status [1:0]
    logic [STATUS_W-1:0] m_axis_tuser;

    shelf_atlas_packer_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // requests waiting for the driver, and placements waiting for the monitor
    t_glyph_req glyph_backlog[$];
    t_placement placement_q[$];
    t_glyph_req offered;

    // idle and stall odds in percent, changed per phase
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // long sink hold-off, asked for once by the stimulus
    bit stall_burst_req  = 1'b0;
    bit stall_burst_done = 1'b0;
    int stall_burst_left = 0;

    int mismatches     = 0;
    int items_accepted = 0;
    int results_seen   = 0;
    int status_seen[4] = '{default: 0};
    int peak_shelves   = 0;
    int peak_entries   = 0;

    // shadow of the shelf memory, only entries below shelves_open are valid
    logic [10:0] shelf_base[MAX_SHELVES_DEF];
    logic [10:0] shelf_h[MAX_SHELVES_DEF];
    logic [10:0] shelf_x[MAX_SHELVES_DEF];
    logic [8:0]  shelf_cnt[MAX_SHELVES_DEF];
    logic [6:0]  shelves_open = '0;

    // first-fit placement on the shadow atlas, returns the answer it must give
    function automatic t_placement predict_glyph(input t_glyph_req g);
        t_placement r;
        int         idx;
        int         base;
        bit         found;
        r.status = STAT_PLACED;
        r.x      = '0;
        r.y      = '0;
        r.shelf  = '0;
        idx      = 0;
        found    = 1'b0;
        if (g.kind == KIND_CLEAR) begin
            shelves_open = '0;
            r.status     = STAT_CLEARED;
            return r;
        end
        // scan open shelves in order, first one tall enough with room wins
        for (int i = 0; i < int'(shelves_open); i++) begin
            if (!found && int'(g.height) <= int'(shelf_h[i]) &&
                int'(shelf_cnt[i]) < MAX_PER_SHELF_DEF &&
                int'(shelf_x[i]) + int'(g.width) <= ATLAS_SIZE_DEF) begin
                found = 1'b1;
                idx   = i;
            end
        end
        if (!found) begin
            // width is judged before any room check
            if (int'(g.width) > ATLAS_SIZE_DEF) begin
                r.status = STAT_TOO_WIDE;
                return r;
            end
            if (int'(shelves_open) >= MAX_SHELVES_DEF) begin
                r.status = STAT_NO_ROOM;
                return r;
            end
            base = 0;
            if (shelves_open != 0)
                base = int'(shelf_base[shelves_open - 1]) + int'(shelf_h[shelves_open - 1]);
            if (base + int'(g.height) > ATLAS_SIZE_DEF) begin
                r.status = STAT_NO_ROOM;
                return r;
            end
            // new shelf right on top of the last one
            idx            = int'(shelves_open);
            shelf_base[idx] = 11'(base);
            shelf_h[idx]    = 11'(g.height);
            shelf_x[idx]    = '0;
            shelf_cnt[idx]  = '0;
            shelves_open    = shelves_open + 1'b1;
            if (int'(shelves_open) > peak_shelves)
                peak_shelves = int'(shelves_open);
        end
        // coordinates wrap to the field width, e.g. column or baseline at the edge
        r.x     = COORD_W'(shelf_x[idx]);
        r.y     = COORD_W'(shelf_base[idx]);
        r.shelf = SHELF_W'(idx);
        shelf_x[idx]   = 11'(int'(shelf_x[idx]) + int'(g.width));
        shelf_cnt[idx] = shelf_cnt[idx] + 1'b1;
        if (int'(shelf_cnt[idx]) > peak_entries)
            peak_entries = int'(shelf_cnt[idx]);
        return r;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    task automatic push_glyph(input logic kind, input int width, input int height);
        t_glyph_req g;
        g.kind   = kind;
        g.width  = DIM_W'(width);
        g.height = DIM_W'(height);
        glyph_backlog.push_back(g);
    endtask

    // an episode starts from an empty atlas and then packs a run of rectangles
    task automatic queue_episode(input t_mix mix, input int count, inout int added);
        push_glyph(KIND_CLEAR, $urandom_range(2048), $urandom_range(2048));
        for (int n = 0; n < count; n++) begin
            case (mix)
                MIX_GLYPHS: begin
                    // mostly small glyphs, now and then a zero dimension
                    push_glyph(KIND_PLACE,
                               ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 48),
                               ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 48));
                end
                MIX_SLIVERS: begin
                    // thin entries pile onto the first shelf until its entry count runs out
                    push_glyph(KIND_PLACE, $urandom_range(4), (n == 0) ? 3 : $urandom_range(3));
                end
                MIX_STRIPS: begin
                    // more than half the width, so every strip needs a shelf of its own
                    push_glyph(KIND_PLACE, $urandom_range(513, 1024), $urandom_range(15));
                end
                MIX_TALL: begin
                    // tall shelves that run out of atlas height
                    push_glyph(KIND_PLACE, $urandom_range(1024), $urandom_range(100, 400));
                end
                default: begin
                    // any sizes up to 2048, with a stray clear now and then
                    push_glyph(($urandom_range(9) == 0) ? KIND_CLEAR : KIND_PLACE,
                               $urandom_range(2048), $urandom_range(2048));
                end
            endcase
        end
        added += count + 1;
    endtask

    // wait until the backlog is sent and every placement came back
    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (glyph_backlog.size() != 0 || s_axis_tvalid || placement_q.size() != 0);
    endtask

    // source driver: predicts on each accepted transaction and offers the next request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                placement_q.push_back(predict_glyph(offered));
                items_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (glyph_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    offered = glyph_backlog.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {offered.height, offered.width};
                    s_axis_tuser  <= offered.kind;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // sink ready: random stalls, plus one long hold-off counted here
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (stall_burst_left != 0) begin
            stall_burst_left <= stall_burst_left - 1;
            m_axis_tready    <= 1'b0;
        end else if (stall_burst_req && !stall_burst_done) begin
            stall_burst_left <= HOLD_CYCLES;
            stall_burst_done <= 1'b1;
            m_axis_tready    <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // result monitor: each result transaction against the oldest prediction
    always @(posedge i_clk) begin : result_monitor
        t_placement want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            status_seen[m_axis_tuser]++;
            if (placement_q.size() == 0) begin
                $error("result with no prediction pending: status %0d, data 0x%08h",
                       m_axis_tuser, m_axis_tdata);
                mismatches++;
            end else begin
                want = placement_q.pop_front();
                check_field("status", int'(want.status), int'(m_axis_tuser));
                check_field("origin_x", int'(want.x), int'(m_axis_tdata[9:0]));
                check_field("origin_y", int'(want.y), int'(m_axis_tdata[19:10]));
                check_field("shelf_index", int'(want.shelf), int'(m_axis_tdata[25:20]));
                check_field("pad bits", 0, int'(m_axis_tdata[31:26]));
            end
        end
    end

    // stimulus and phase control
    initial begin
        int added;
        t_mix mix;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed corners, no idling
        push_glyph(KIND_CLEAR, 2048, 2048);     // clear carrying ignored sizes
        push_glyph(KIND_PLACE, 0, 0);           // zero size opens a zero-height shelf
        push_glyph(KIND_PLACE, 1024, 0);        // exactly fills the shelf width
        push_glyph(KIND_PLACE, 0, 0);           // zero width at column 1024 wraps
        push_glyph(KIND_PLACE, 2048, 5);        // widest request
        push_glyph(KIND_PLACE, 1025, 0);        // one past the atlas width
        push_glyph(KIND_PLACE, 1, 2048);        // taller than the atlas
        push_glyph(KIND_PLACE, 1024, 512);
        push_glyph(KIND_PLACE, 1024, 512);      // atlas height now used up
        push_glyph(KIND_PLACE, 1, 0);           // zero-height shelf at baseline 1024 wraps
        push_glyph(KIND_PLACE, 1, 1);           // no height left
        push_glyph(KIND_PLACE, 0, 0);
        push_glyph(KIND_CLEAR, 0, 0);
        push_glyph(KIND_PLACE, 2048, 2048);     // too wide wins over out of room
        push_glyph(KIND_PLACE, 1024, 1024);     // one shelf covering the atlas
        push_glyph(KIND_PLACE, 1, 1);
        push_glyph(KIND_CLEAR, 1234, 777);
        push_glyph(KIND_PLACE, 17, 9);
        push_glyph(KIND_PLACE, 5, 3);           // shorter glyph shares shelf 0
        push_glyph(KIND_PLACE, 3, 12);          // taller one opens shelf 1
        push_glyph(KIND_PLACE, 1000, 9);
        push_glyph(KIND_PLACE, 3, 9);           // shelf 0 full, falls to shelf 1
        wait_drained();

        // random phases: none, source idle, sink stall, both
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
                default: begin send_idle_pct = 12; recv_stall_pct = 12; end
            endcase
            added = 0;
            // make sure every phase fills the shelf count or one shelf's entries
            if (phase % 2 == 0)
                queue_episode(MIX_STRIPS, $urandom_range(70, 80), added);
            else
                queue_episode(MIX_SLIVERS, $urandom_range(280, 300), added);
            while (added < PHASE_ITEMS) begin
                case ($urandom_range(9))
                    0, 1, 2, 3: mix = MIX_GLYPHS;
                    4:          mix = MIX_SLIVERS;
                    5, 6:       mix = MIX_STRIPS;
                    7:          mix = MIX_TALL;
                    default:    mix = MIX_WILD;
                endcase
                case (mix)
                    MIX_SLIVERS: queue_episode(mix, $urandom_range(100, 300), added);
                    MIX_STRIPS:  queue_episode(mix, $urandom_range(40, 80), added);
                    MIX_TALL:    queue_episode(mix, $urandom_range(6, 15), added);
                    MIX_WILD:    queue_episode(mix, $urandom_range(10, 40), added);
                    default:     queue_episode(mix, $urandom_range(40, 120), added);
                endcase
            end
            // sink holds off while the source keeps offering, so the input backs up
            if (phase == 0)
                stall_burst_req = 1'b1;
            wait_drained();
        end

        // let any stray late result show up
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("run: %0d requests in, %0d results out", items_accepted, results_seen);
        $display("run: %0d placed, %0d too wide, %0d out of room, %0d cleared",
                 status_seen[STAT_PLACED], status_seen[STAT_TOO_WIDE],
                 status_seen[STAT_NO_ROOM], status_seen[STAT_CLEARED]);
        $display("run: peak %0d open shelves, peak %0d entries on one shelf, %0d mismatches",
                 peak_shelves, peak_entries, mismatches);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // watchdog
    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("timeout with %0d results still pending", placement_q.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
